>>> hw/rtl/tun_pkg.sv
`default_nettype none

package tun_pkg;

   // Vertex coordinates are signed Q16.16.
   localparam int CoordWidth = 32;

   // Unit vectors are signed Q2.30.
   localparam int UnitWidth = 32;
   localparam int UnitFrac = 30;
   localparam logic [UnitWidth-1:0] UnitOne = UnitWidth'(1) << UnitFrac;

   // An edge is an exact difference of two coordinates.
   localparam int EdgeWidth = CoordWidth + 1;

   // A cross product of two unit vectors stays within plus or minus 2^61.
   localparam int CrossWidth = 2 * UnitWidth - 1;

   typedef struct packed {
      logic signed [CoordWidth-1:0] a_x;
      logic signed [CoordWidth-1:0] a_y;
      logic signed [CoordWidth-1:0] a_z;
      logic signed [CoordWidth-1:0] b_x;
      logic signed [CoordWidth-1:0] b_y;
      logic signed [CoordWidth-1:0] b_z;
      logic signed [CoordWidth-1:0] c_x;
      logic signed [CoordWidth-1:0] c_y;
      logic signed [CoordWidth-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [UnitWidth-1:0] normal_x;
      logic signed [UnitWidth-1:0] normal_y;
      logic signed [UnitWidth-1:0] normal_z;
   } rsp_type;

   typedef logic [2:0][UnitWidth-1:0] unit_vec_type;
   typedef logic [2:0][CrossWidth-1:0] cross_vec_type;

endpackage

`default_nettype wire

>>> hw/rtl/tun_norm.sv
`default_nettype none

module tun_norm #(
   parameter int IN_W = tun_pkg::EdgeWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [2:0][IN_W-1:0]  in_vec,
   output logic                  out_valid,
   input  logic                  out_stall,
   output tun_pkg::unit_vec_type out_unit
);
   import tun_pkg::*;

   localparam int MagW = IN_W;
   localparam int ScW = UnitFrac + 1;
   localparam int XW = MagW + ScW;
   localparam int PW = $clog2(MagW + 1);
   localparam int SqW = 2 * ScW + 2;
   localparam int RootW = SqW / 2;
   localparam int RemW = RootW + 3;
   localparam int QW = ScW;
   localparam int DRemW = RootW + 1;
   localparam int NSqrt = RootW;
   localparam int NDiv = QW;
   localparam int NStage = 5 + NSqrt + NDiv + 1;

   typedef struct packed {
      logic [RemW-1:0]          rem;
      logic [RootW-1:0]         root;
      logic [SqW-1:0]           src;
      logic [2:0][ScW-1:0]      sc;
      logic [2:0]               neg;
      logic                     zero;
   } sq_stage_type;

   typedef struct packed {
      logic [2:0][DRemW-1:0]    rem;
      logic [2:0][QW-1:0]       feed;
      logic [2:0][QW-1:0]       quo;
      logic [RootW-1:0]         len;
      logic [2:0]               neg;
      logic                     zero;
   } dv_stage_type;

   // One bit of the square root: bring down two bits and try the next root bit.
   function automatic sq_stage_type sqrt_step(sq_stage_type s);
      sq_stage_type r;
      logic [RemW-1:0] rem2;
      logic [RemW-1:0] trial;
      r = s;
      rem2 = {s.rem[RemW-3:0], s.src[SqW-1 -: 2]};
      trial = RemW'({s.root, 2'b01});
      r.src = {s.src[SqW-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem = rem2 - trial;
         r.root = {s.root[RootW-2:0], 1'b1};
      end else begin
         r.rem = rem2;
         r.root = {s.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of a restoring division in each of the three lanes.
   function automatic dv_stage_type div_step(dv_stage_type s);
      dv_stage_type r;
      logic [DRemW-1:0] rem2;
      r = s;
      for (int i = 0; i < 3; i++) begin
         rem2 = {s.rem[i][DRemW-2:0], s.feed[i][QW-1]};
         r.feed[i] = {s.feed[i][QW-2:0], 1'b0};
         if (rem2 >= DRemW'(s.len)) begin
            r.rem[i] = rem2 - DRemW'(s.len);
            r.quo[i] = {s.quo[i][QW-2:0], 1'b1};
         end else begin
            r.rem[i] = rem2;
            r.quo[i] = {s.quo[i][QW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic                    en;
   logic [NStage-1:0]       vld_ff;
   logic [NStage-1:0]       vld_in;

   logic [2:0][MagW-1:0]    mag0_ff, mag0_in;
   logic [2:0]              neg0_ff, neg0_in;

   logic [MagW-1:0]         orv;
   logic [2:0][MagW-1:0]    mag1_ff;
   logic [2:0]              neg1_ff;
   logic [PW-1:0]           sh1_ff, sh1_in;
   logic                    zero1_ff, zero1_in;

   logic [2:0][ScW-1:0]     sc2_ff, sc2_in;
   logic [2:0]              neg2_ff;
   logic                    zero2_ff;

   logic [2:0][2*ScW-1:0]   sqr3_ff, sqr3_in;
   logic [2:0][ScW-1:0]     sc3_ff;
   logic [2:0]              neg3_ff;
   logic                    zero3_ff;

   logic [SqW-1:0]          sum4_ff, sum4_in;
   logic [2:0][ScW-1:0]     sc4_ff;
   logic [2:0]              neg4_ff;
   logic                    zero4_ff;

   sq_stage_type            sq_src [NSqrt];
   sq_stage_type            sq_in  [NSqrt];
   sq_stage_type            sq_ff  [NSqrt];

   dv_stage_type            dv_src [NDiv];
   dv_stage_type            dv_in  [NDiv];
   dv_stage_type            dv_ff  [NDiv];

   unit_vec_type            out_ff, out_in;

   // The whole pipeline moves together unless the last beat is held.
   assign en = !(vld_ff[NStage-1] && out_stall);
   assign in_stall = !en;
   assign vld_in = {vld_ff[NStage-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: magnitudes and signs.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg0_in[i] = in_vec[i][IN_W-1];
         mag0_in[i] = neg0_in[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
   end

   // Stage 1: position of the leading one over all three magnitudes.
   always_comb begin
      orv = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      sh1_in = '0;
      for (int i = 0; i < MagW; i++) begin
         if (orv[i]) begin
            sh1_in = PW'(i + 1);
         end
      end
      zero1_in = (orv == '0);
   end

   // Stage 2: scale so the largest magnitude has its leading one at bit 30.
   always_comb begin
      logic [XW-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide = {mag1_ff[i], {ScW{1'b0}}} >> sh1_ff;
         sc2_in[i] = wide[ScW-1:0];
      end
   end

   // Stage 3: squares. Stage 4: their sum.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqr3_in[i] = sc2_ff[i] * sc2_ff[i];
      end
      sum4_in = SqW'(sqr3_ff[0]) + SqW'(sqr3_ff[1]) + SqW'(sqr3_ff[2]);
   end

   // Square root stages, one root bit each.
   always_comb begin
      sq_src[0].rem = '0;
      sq_src[0].root = '0;
      sq_src[0].src = sum4_ff;
      sq_src[0].sc = sc4_ff;
      sq_src[0].neg = neg4_ff;
      sq_src[0].zero = zero4_ff;
      for (int k = 1; k < NSqrt; k++) begin
         sq_src[k] = sq_ff[k-1];
      end
      for (int k = 0; k < NSqrt; k++) begin
         sq_in[k] = sqrt_step(sq_src[k]);
      end
   end

   // Division stages: each magnitude times 2^30 over the length.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_src[0].rem[i] = DRemW'(sq_ff[NSqrt-1].sc[i][ScW-1:1]);
         dv_src[0].feed[i] = {sq_ff[NSqrt-1].sc[i][0], {(QW-1){1'b0}}};
         dv_src[0].quo[i] = '0;
      end
      dv_src[0].len = sq_ff[NSqrt-1].root;
      dv_src[0].neg = sq_ff[NSqrt-1].neg;
      dv_src[0].zero = sq_ff[NSqrt-1].zero;
      for (int k = 1; k < NDiv; k++) begin
         dv_src[k] = dv_ff[k-1];
      end
      for (int k = 0; k < NDiv; k++) begin
         dv_in[k] = div_step(dv_src[k]);
      end
   end

   // Output stage: clamp, restore the signs, and zero a zero-length vector.
   always_comb begin
      logic [QW-1:0] q;
      logic [UnitWidth-1:0] qx;
      for (int i = 0; i < 3; i++) begin
         q = dv_ff[NDiv-1].quo[i];
         if (q > QW'(UnitOne)) begin
            q = QW'(UnitOne);
         end
         qx = UnitWidth'(q);
         if (dv_ff[NDiv-1].zero) begin
            out_in[i] = '0;
         end else begin
            out_in[i] = dv_ff[NDiv-1].neg[i] ? (~qx + 1'b1) : qx;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         mag0_ff <= mag0_in;
         neg0_ff <= neg0_in;
         mag1_ff <= mag0_ff;
         neg1_ff <= neg0_ff;
         sh1_ff <= sh1_in;
         zero1_ff <= zero1_in;
         sc2_ff <= sc2_in;
         neg2_ff <= neg1_ff;
         zero2_ff <= zero1_ff;
         sqr3_ff <= sqr3_in;
         sc3_ff <= sc2_ff;
         neg3_ff <= neg2_ff;
         zero3_ff <= zero2_ff;
         sum4_ff <= sum4_in;
         sc4_ff <= sc3_ff;
         neg4_ff <= neg3_ff;
         zero4_ff <= zero3_ff;
         for (int k = 0; k < NSqrt; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int k = 0; k < NDiv; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[NStage-1];
   assign out_unit = out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tun_cross.sv
`default_nettype none

module tun_cross (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  tun_pkg::unit_vec_type  in_u,
   input  tun_pkg::unit_vec_type  in_v,
   output logic                   out_valid,
   input  logic                   out_stall,
   output tun_pkg::cross_vec_type out_cross
);
   import tun_pkg::*;

   localparam int ProdW = 2 * UnitWidth;

   logic                    en;
   logic [1:0]              vld_ff;
   logic signed [ProdW-1:0] prod_ff [6];
   logic signed [ProdW-1:0] prod_in [6];
   cross_vec_type           cr_ff, cr_in;

   assign en = !(vld_ff[1] && out_stall);
   assign in_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   // First stage: the six partial products.
   always_comb begin
      prod_in[0] = $signed(in_u[1]) * $signed(in_v[2]);
      prod_in[1] = $signed(in_u[2]) * $signed(in_v[1]);
      prod_in[2] = $signed(in_u[2]) * $signed(in_v[0]);
      prod_in[3] = $signed(in_u[0]) * $signed(in_v[2]);
      prod_in[4] = $signed(in_u[0]) * $signed(in_v[1]);
      prod_in[5] = $signed(in_u[1]) * $signed(in_v[0]);
   end

   // Second stage: the three differences.
   always_comb begin
      logic signed [ProdW-1:0] d;
      for (int i = 0; i < 3; i++) begin
         d = prod_ff[2*i] - prod_ff[2*i+1];
         cr_in[i] = d[CrossWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         cr_ff <= cr_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_cross = cr_ff;

endmodule

`default_nettype wire

>>> hw/rtl/triangle_unit_normal.sv
`default_nettype none
// The path from an accepted triangle to its normal has one edge stage, two normalizers
// of 69 stages each, and two cross product stages. Throughput: one triangle per cycle
// while no result beat is held; the square root and divider pipelines set the depth.
// A held result beat freezes the pipeline until it is taken.
// Reset is synchronous and clears all valid bits; payload registers are not reset.

module triangle_unit_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tun_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tun_pkg::rsp_type rsp_payload
);
   import tun_pkg::*;

   logic                        e_vld_ff;
   logic                        e_en;
   logic [2:0][EdgeWidth-1:0]   e1_ff, e1_in;
   logic [2:0][EdgeWidth-1:0]   e2_ff, e2_in;

   logic                        n1_stall, n2_stall;
   logic                        n1_valid, n2_valid;
   unit_vec_type                n1_unit, n2_unit;
   logic                        cr_stall, cr_valid;
   cross_vec_type               cr_vec;
   logic                        nf_stall;
   unit_vec_type                nf_unit;

   // Edge stage: exact differences from the first vertex.
   always_comb begin
      e1_in[0] = {req_payload.b_x[CoordWidth-1], req_payload.b_x}
               - {req_payload.a_x[CoordWidth-1], req_payload.a_x};
      e1_in[1] = {req_payload.b_y[CoordWidth-1], req_payload.b_y}
               - {req_payload.a_y[CoordWidth-1], req_payload.a_y};
      e1_in[2] = {req_payload.b_z[CoordWidth-1], req_payload.b_z}
               - {req_payload.a_z[CoordWidth-1], req_payload.a_z};
      e2_in[0] = {req_payload.c_x[CoordWidth-1], req_payload.c_x}
               - {req_payload.a_x[CoordWidth-1], req_payload.a_x};
      e2_in[1] = {req_payload.c_y[CoordWidth-1], req_payload.c_y}
               - {req_payload.a_y[CoordWidth-1], req_payload.a_y};
      e2_in[2] = {req_payload.c_z[CoordWidth-1], req_payload.c_z}
               - {req_payload.a_z[CoordWidth-1], req_payload.a_z};
   end

   assign e_en = !(e_vld_ff && (n1_stall || n2_stall));
   assign req_stall = !e_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (e_en) begin
         e_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
   end

   // Both edge normalizers run in lockstep.
   tun_norm #(.IN_W(EdgeWidth)) u_norm_e1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_vld_ff),
      .in_stall  (n1_stall),
      .in_vec    (e1_ff),
      .out_valid (n1_valid),
      .out_stall (cr_stall),
      .out_unit  (n1_unit)
   );

   tun_norm #(.IN_W(EdgeWidth)) u_norm_e2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_vld_ff),
      .in_stall  (n2_stall),
      .in_vec    (e2_ff),
      .out_valid (n2_valid),
      .out_stall (cr_stall),
      .out_unit  (n2_unit)
   );

   tun_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_valid && n2_valid),
      .in_stall  (cr_stall),
      .in_u      (n1_unit),
      .in_v      (n2_unit),
      .out_valid (cr_valid),
      .out_stall (nf_stall),
      .out_cross (cr_vec)
   );

   tun_norm #(.IN_W(CrossWidth)) u_norm_face (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid),
      .in_stall  (nf_stall),
      .in_vec    (cr_vec),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_unit  (nf_unit)
   );

   assign rsp_payload.normal_x = nf_unit[0];
   assign rsp_payload.normal_y = nf_unit[1];
   assign rsp_payload.normal_z = nf_unit[2];

endmodule

`default_nettype wire

>>> hw/rtl/tun_checker.sv
`default_nettype none

module tun_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tun_pkg::rsp_type rsp_payload
);
   import tun_pkg::*;

   // A held result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while held");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   // The input side only waits while a result beat is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // Every component is a Q2.30 value within plus or minus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed(rsp_payload.normal_x) <= $signed(UnitOne)) &&
         ($signed(rsp_payload.normal_x) >= -$signed(UnitOne)) &&
         ($signed(rsp_payload.normal_y) <= $signed(UnitOne)) &&
         ($signed(rsp_payload.normal_y) >= -$signed(UnitOne)) &&
         ($signed(rsp_payload.normal_z) <= $signed(UnitOne)) &&
         ($signed(rsp_payload.normal_z) >= -$signed(UnitOne)))
      else $error("normal component out of range");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);

`default_nettype wire

>>> tb/triangle_unit_normal_tb.sv
`default_nettype none

module triangle_unit_normal_tb;
   import tun_pkg::*;

   localparam int Latency = 141;
   localparam int CycleLimit = 1000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type normal_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      hold_rsp = 1'b0;
   bit      quiet_rsp = 1'b0;
   int      hold_cycles = 0;

   triangle_unit_normal u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Integer square root, bit by bit.
   function automatic logic [63:0] sqrt_floor(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scale a vector to Q2.30 unit length; zero stays zero.
   function automatic void make_unit(input longint v[3], output longint u[3]);
      logic [63:0] m[3];
      logic [63:0] top;
      logic [63:0] s;
      logic [63:0] len;
      logic [63:0] q;
      top = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return;
      end
      while (top >= (64'd1 << 31)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 30)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
      len = sqrt_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] << 30) / len;
         if (q > (64'd1 << 30)) q = 64'd1 << 30;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic rsp_type face_normal(req_type t);
      longint e1[3], e2[3], n1[3], n2[3], cr[3], nr[3];
      rsp_type r;
      e1[0] = longint'(t.b_x) - longint'(t.a_x);
      e1[1] = longint'(t.b_y) - longint'(t.a_y);
      e1[2] = longint'(t.b_z) - longint'(t.a_z);
      e2[0] = longint'(t.c_x) - longint'(t.a_x);
      e2[1] = longint'(t.c_y) - longint'(t.a_y);
      e2[2] = longint'(t.c_z) - longint'(t.a_z);
      make_unit(e1, n1);
      make_unit(e2, n2);
      cr[0] = n1[1] * n2[2] - n1[2] * n2[1];
      cr[1] = n1[2] * n2[0] - n1[0] * n2[2];
      cr[2] = n1[0] * n2[1] - n1[1] * n2[0];
      make_unit(cr, nr);
      r.normal_x = nr[0][31:0];
      r.normal_y = nr[1][31:0];
      r.normal_z = nr[2][31:0];
      return r;
   endfunction

   // Send one triangle beat; the expectation is queued when it is accepted.
   // Valid stays high after the beat until the next gap or the drain.
   task automatic send_triangle(req_type t, bit allow_gap);
      int gap;
      if (allow_gap) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      normal_queue.push_back(face_normal(t));
   endtask

   function automatic req_type random_triangle();
      req_type t;
      logic signed [31:0] base;
      int shift;
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      // Often keep edges short so small differences get exercised.
      if ($urandom_range(0, 2) == 0) begin
         shift = $urandom_range(0, 30);
         base = $urandom;
         t.b_x = base + ($signed($urandom) >>> shift);
         t.b_y = t.a_y + ($signed($urandom) >>> shift);
         t.b_z = t.a_z + ($signed($urandom) >>> shift);
         t.a_x = base;
         t.c_x = base + ($signed($urandom) >>> shift);
         t.c_y = t.a_y + ($signed($urandom) >>> shift);
         t.c_z = t.a_z + ($signed($urandom) >>> shift);
      end
      return t;
   endfunction

   function automatic req_type make_triangle(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz);
      req_type t;
      t = {ax, ay, az, bx, by, bz, cx, cy, cz};
      return t;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (normal_queue.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   // Extremes, axes and degenerate triangles.
   task automatic test_directed();
      localparam int Mx = 32'h7fffffff;
      localparam int Mn = 32'h80000000;
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 0, 65536, 0, 65536, 0, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 0, 0, 65536, 65536, 0, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 131072, 0, 0), 1'b0);
      send_triangle(make_triangle(5, 6, 7, 5, 6, 7, 9, 1, 2), 1'b0);
      send_triangle(make_triangle(1, 2, 3, 4, 5, 6, 4, 5, 6), 1'b0);
      send_triangle(make_triangle(Mn, Mn, Mn, Mx, Mx, Mx, Mx, Mn, Mx), 1'b0);
      send_triangle(make_triangle(Mx, Mx, Mx, Mn, Mn, Mn, Mn, Mx, Mn), 1'b0);
      send_triangle(make_triangle(Mn, 0, 0, Mx, 0, 0, Mn, Mx, 0), 1'b0);
      send_triangle(make_triangle(-1, -1, -1, Mx, Mn, Mx, Mn, Mx, Mn), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, Mx, Mx, 0, Mx, Mx - 1, 0), 1'b0);
      send_triangle(make_triangle(0, 0, 0, 1, 1, 1, Mx, Mx, Mx - 1), 1'b0);
      send_triangle(make_triangle(3, -4, 5, -7, 8, -9, 10, 11, -12), 1'b0);
      send_triangle(make_triangle(0, 0, 0, -65536, 0, 0, 0, -65536, 0), 1'b0);
      wait_drained();
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_triangle(random_triangle(), 1'b1);
   endtask

   // Receiver holds off while triangles keep coming, filling the pipeline.
   task automatic test_backpressure();
      hold_cycles = 400;
      hold_rsp = 1'b1;
      for (int i = 0; i < 200; i++) send_triangle(random_triangle(), 1'b0);
      wait_drained();
   endtask

   // Back to back without any stalls on either side.
   task automatic test_streaming();
      quiet_rsp = 1'b1;
      for (int i = 0; i < 100; i++) send_triangle(random_triangle(), 1'b0);
      wait_drained();
      quiet_rsp = 1'b0;
   endtask

   // Receiver stall pattern: mostly short stalls, now and then a long hold.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         if (hold_cycles == 0) hold_rsp <= 1'b0;
         else hold_cycles <= hold_cycles - 1;
      end else if (quiet_rsp || reset) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= $urandom_range(10, 60);
         hold_rsp <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= ~rsp_stall;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normal_queue.size() == 0) begin
            $display("%0t: unexpected normal %h", $time, rsp_payload);
            error_count <= error_count + 1;
         end else begin
            want = normal_queue.pop_front();
            if (rsp_payload.normal_x !== want.normal_x ||
                rsp_payload.normal_y !== want.normal_y ||
                rsp_payload.normal_z !== want.normal_z) begin
               $display("%0t: normal mismatch expected %h %h %h actual %h %h %h", $time,
                        want.normal_x, want.normal_y, want.normal_z,
                        rsp_payload.normal_x, rsp_payload.normal_y, rsp_payload.normal_z);
               error_count <= error_count + 1;
            end
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150);
      wait_drained();
      test_backpressure();
      test_streaming();
      test_random(134);
      wait_drained();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/tun_pkg.sv
hw/rtl/tun_norm.sv
hw/rtl/tun_cross.sv
hw/rtl/triangle_unit_normal.sv
hw/rtl/tun_checker.sv
tb/triangle_unit_normal_tb.sv
